FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the fixed-point integer-to-text unit.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int MAX_CHARS  = 30;
    localparam int BIN_W      = 32;
    localparam int NUM_DIGITS = 10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [4:0]  min_width;
        logic        [7:0]  fill_char;
        logic        [3:0]  decimals;
    } in_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } out_t;

    typedef enum logic [1:0] {
        SEL_FILL  = 2'd0,
        SEL_SIGN  = 2'd1,
        SEL_POINT = 2'd2,
        SEL_DIGIT = 2'd3
    } char_sel_t;

    typedef struct packed {
        logic      load;
        logic      shift;
        logic      emit;
        logic      last;
        char_sel_t sel;
        logic [3:0] idx;
    } cmd_t;

    typedef struct packed {
        logic       neg;
        logic [3:0] dec;
        logic [3:0] nd_m1;
        logic [4:0] fill_cnt;
    } status_t;

endpackage

FILE: rtl/int_to_decimal_ascii_fixed_point_unit.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_fixed_point_unit
// Signed 32-bit integer to fixed-point decimal ASCII text, one character
// per cycle, most significant first.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The value is converted
// to BCD by a shift-add-3 loop, one bit per cycle, then a prep state sizes
// the text, then the text streams out one character per cycle with
// result_valid high, last set on the final character, 1 to 30 characters in
// all. No new item is taken until the last one is out. The receiver cannot
// stall: each character is present for one cycle only and must be taken then.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_fixed_point_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  itoa_pkg::in_t  operand,
    output logic           busy,
    output logic           result_valid,
    output itoa_pkg::out_t result
);

    itoa_pkg::cmd_t    cmd;
    itoa_pkg::status_t status;

    itoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    itoa_datapath u_datapath (
        .clk     (clk),
        .operand (operand),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

    assign result_valid = cmd.emit;

endmodule

FILE: rtl/itoa_datapath.sv
// ----------------------------------------------------------------------------
// itoa_datapath
// Operand registers, shift-add-3 binary to BCD converter, length logic and
// output character select.
// ----------------------------------------------------------------------------
module itoa_datapath (
    input  logic              clk,
    input  itoa_pkg::in_t     operand,
    input  itoa_pkg::cmd_t    cmd,
    output itoa_pkg::status_t status,
    output itoa_pkg::out_t    result
);

    logic [itoa_pkg::BIN_W-1:0] bin_reg, bin_next;
    logic [3:0] bcd_reg  [itoa_pkg::NUM_DIGITS];
    logic [3:0] bcd_next [itoa_pkg::NUM_DIGITS];
    logic [3:0] adj      [itoa_pkg::NUM_DIGITS];
    logic       neg_reg;
    logic [3:0] dec_reg;
    logic [4:0] minw_reg;
    logic [7:0] fill_reg;

    logic [4:0] ndig;
    logic [4:0] nd;
    logic [4:0] len;
    logic [4:0] minw_c;
    logic [3:0] digit;
    logic [31:0] raw;

    assign raw = operand.value;

    always_comb
    begin
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
        begin
            if (i == 0)
            begin
                bcd_next[i] = {adj[i][2:0], bin_reg[itoa_pkg::BIN_W-1]};
            end
            else
            begin
                bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end
        bin_next = {bin_reg[itoa_pkg::BIN_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg  <= raw[31] ? (32'd0 - raw) : raw;
            neg_reg  <= raw[31];
            dec_reg  <= operand.decimals;
            minw_reg <= operand.min_width;
            fill_reg <= operand.fill_char;
            for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
            begin
                bcd_reg[i] <= 4'd0;
            end
        end
        else if (cmd.shift)
        begin
            bin_reg <= bin_next;
            for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
            begin
                bcd_reg[i] <= bcd_next[i];
            end
        end
    end

    // significant digit count, at least one
    always_comb
    begin
        ndig = 5'd1;
        for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                ndig = 5'(i + 1);
            end
        end
    end

    always_comb
    begin
        if (dec_reg == 4'd0 || ndig > {1'b0, dec_reg})
        begin
            nd = ndig;
        end
        else
        begin
            nd = {1'b0, dec_reg} + 5'd1;
        end
        len    = nd + {4'd0, (dec_reg != 4'd0)} + {4'd0, neg_reg};
        minw_c = (32'(minw_reg) > itoa_pkg::MAX_CHARS) ? 5'(itoa_pkg::MAX_CHARS) : minw_reg;
    end

    assign status.neg      = neg_reg;
    assign status.dec      = dec_reg;
    assign status.nd_m1    = 4'(nd - 5'd1);
    assign status.fill_cnt = (minw_c > len) ? minw_c - len : 5'd0;

    assign digit = (cmd.idx < 4'(itoa_pkg::NUM_DIGITS)) ? bcd_reg[cmd.idx] : 4'd0;

    always_comb
    begin
        unique case (cmd.sel)
            itoa_pkg::SEL_FILL:  result.text_char = fill_reg;
            itoa_pkg::SEL_SIGN:  result.text_char = itoa_pkg::CHAR_MINUS;
            itoa_pkg::SEL_POINT: result.text_char = itoa_pkg::CHAR_POINT;
            itoa_pkg::SEL_DIGIT: result.text_char = itoa_pkg::CHAR_ZERO + {4'd0, digit};
            default:             result.text_char = fill_reg;
        endcase
        result.last = cmd.last;
    end

endmodule

FILE: rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: conversion bit count, then fill, sign, digits and point.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  itoa_pkg::status_t status,
    output logic              busy,
    output itoa_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CONV  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_FILL  = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_DIGIT = 7'b0100000,
        ST_POINT = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] bit_cnt_reg, bit_cnt_next;
    logic [4:0] fill_cnt_reg, fill_cnt_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= 5'd0;
            fill_cnt_reg <= 5'd0;
            idx_reg      <= 4'd0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
            idx_reg      <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        fill_cnt_next = fill_cnt_reg;
        idx_next      = idx_reg;
        cmd.load      = 1'b0;
        cmd.shift     = 1'b0;
        cmd.emit      = 1'b0;
        cmd.last      = 1'b0;
        cmd.sel       = itoa_pkg::SEL_DIGIT;
        cmd.idx       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = 5'd0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift    = 1'b1;
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'(itoa_pkg::BIN_W - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                fill_cnt_next = status.fill_cnt;
                idx_next      = status.nd_m1;
                if (status.fill_cnt != 5'd0)
                begin
                    state_next = ST_FILL;
                end
                else if (status.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_FILL:
            begin
                cmd.emit      = 1'b1;
                cmd.sel       = itoa_pkg::SEL_FILL;
                fill_cnt_next = fill_cnt_reg - 5'd1;
                if (fill_cnt_reg == 5'd1)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = itoa_pkg::SEL_SIGN;
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.emit = 1'b1;
                cmd.sel  = itoa_pkg::SEL_DIGIT;
                if (idx_reg == 4'd0)
                begin
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 4'd1;
                    if (status.dec != 4'd0 && idx_reg == status.dec)
                    begin
                        state_next = ST_POINT;
                    end
                end
            end
            ST_POINT:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = itoa_pkg::SEL_POINT;
                state_next = ST_DIGIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: test/int_to_decimal_ascii_fixed_point_unit_tb.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_fixed_point_unit_tb
// Drives signed values with width, fill and decimal settings into the
// integer-to-text unit. A local model builds the expected character stream
// for each accepted item, and every emitted character is checked in order.
// The sender runs with no idling, heavy idling and light idling.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_fixed_point_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        itoa_pkg::in_t op;
        int unsigned   idle_pct;
    } pend_item_t;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    itoa_pkg::in_t  operand = '0;
    logic busy;
    logic result_valid;
    itoa_pkg::out_t result;

    pend_item_t     pending_items[$];
    itoa_pkg::out_t expected_chars[$];
    itoa_pkg::out_t want_char;
    int             errors       = 0;
    int             stall_cycles = 0;

    always #4 clk = ~clk;

    int_to_decimal_ascii_fixed_point_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operand      (operand),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    function automatic void predict_text(input itoa_pkg::in_t op);
        logic [7:0]     rev[$];
        logic           neg;
        logic [31:0]    mag;
        int             minw;
        int             dec;
        int             n;
        itoa_pkg::out_t ch;
        neg  = op.value[31];
        mag  = neg ? (32'd0 - op.value) : op.value;
        minw = (int'(op.min_width) > itoa_pkg::MAX_CHARS) ? itoa_pkg::MAX_CHARS
                                                         : int'(op.min_width);
        dec  = int'(op.decimals);
        if (mag == 32'd0)
            rev.push_back(itoa_pkg::CHAR_ZERO);
        else
        begin
            while (mag != 32'd0)
            begin
                if (dec != 0 && rev.size() == dec)
                    rev.push_back(itoa_pkg::CHAR_POINT);
                rev.push_back(itoa_pkg::CHAR_ZERO + 8'(mag % 32'd10));
                mag = mag / 32'd10;
            end
        end
        // not enough digits for the fraction: pad and lead with "0."
        if (rev.size() <= dec)
        begin
            while (rev.size() < dec)
                rev.push_back(itoa_pkg::CHAR_ZERO);
            rev.push_back(itoa_pkg::CHAR_POINT);
            rev.push_back(itoa_pkg::CHAR_ZERO);
        end
        if (neg)
            rev.push_back(itoa_pkg::CHAR_MINUS);
        while (rev.size() < minw)
            rev.push_back(op.fill_char);
        n = (rev.size() > itoa_pkg::MAX_CHARS) ? itoa_pkg::MAX_CHARS : rev.size();
        for (int k = 0; k < n; k++)
        begin
            ch.text_char = rev[n - 1 - k];
            ch.last      = (k == n - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    task automatic add_item(input logic signed [31:0] value, input logic [4:0] min_width,
                            input logic [7:0] fill_char, input logic [3:0] decimals,
                            input int unsigned idle_pct);
        pend_item_t it;
        it.op.value     = value;
        it.op.min_width = min_width;
        it.op.fill_char = fill_char;
        it.op.decimals  = decimals;
        it.idle_pct     = idle_pct;
        pending_items.push_back(it);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_text(operand);
            if (!start || !busy)
            begin
                if (pending_items.size() != 0 &&
                    $urandom_range(0, 99) >= pending_items[0].idle_pct)
                begin
                    operand <= pending_items[0].op;
                    pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, result.text_char, result.last);
            end
            else
            begin
                want_char = expected_chars.pop_front();
                if (result.text_char !== want_char.text_char || result.last !== want_char.last)
                begin
                    errors++;
                    $display("%0t: char mismatch: expected %h last %b, actual %h last %b",
                             $time, want_char.text_char, want_char.last,
                             result.text_char, result.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("int_to_decimal_ascii_fixed_point_unit: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [31:0] v;
        int unsigned        idle;

        add_item(32'sd0,           5'd0,  " ",   4'd0,  0);
        add_item(32'sd0,           5'd0,  " ",   4'd3,  0);
        add_item(32'sd0,           5'd30, "*",   4'd15, 0);
        add_item(32'sd1,           5'd0,  " ",   4'd1,  0);
        add_item(-32'sd1,          5'd0,  " ",   4'd0,  0);
        add_item(-32'sd1,          5'd5,  " ",   4'd2,  0);
        add_item(32'sh7FFFFFFF,    5'd0,  8'h00, 4'd0,  0);
        add_item(32'sh80000000,    5'd0,  8'hFF, 4'd0,  0);
        add_item(32'sh80000000,    5'd31, "#",   4'd15, 0);
        add_item(32'sh80000000,    5'd30, 8'h55, 4'd10, 0);
        add_item(32'sd12345,       5'd0,  " ",   4'd5,  0);
        add_item(-32'sd12345,      5'd10, "0",   4'd5,  0);
        add_item(32'sd123456,      5'd12, " ",   4'd3,  0);
        add_item(-32'sd987654321,  5'd31, 8'h00, 4'd9,  0);
        add_item(32'sd100,         5'd3,  "x",   4'd0,  0);
        add_item(32'sd1000,        5'd2,  "x",   4'd0,  0);
        add_item(32'sh7FFFFFFF,    5'd30, 8'hFF, 4'd10, 0);
        add_item(-32'sd5,          5'd30, " ",   4'd15, 0);
        add_item(32'sd10,          5'd4,  "_",   4'd1,  0);
        add_item(-32'sd99,         5'd1,  " ",   4'd14, 0);
        add_item(32'sd7,           5'd31, 8'hAA, 4'd0,  0);
        add_item(32'sh7FFFFFFF,    5'd18, 8'h55, 4'd15, 0);

        for (int i = 0; i < 350; i++)
        begin
            idle = (i < 110) ? 0 : (i < 230) ? 88 : 6;
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 999);
                2: v = $urandom_range(0, 99999);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh80000000;
                        1: v = 32'sh7FFFFFFF;
                        2: v = 32'sd0;
                        default: v = $urandom_range(999999, 999999999);
                    endcase
                end
            endcase
            if (v != 32'sh80000000 && $urandom_range(0, 1))
                v = -v;
            add_item(v, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), idle);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || start || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_chars.size() != 0)
        begin
            errors++;
            $display("%0t: missing chars: expected %0d more, actual none",
                     $time, expected_chars.size());
        end
        if (errors == 0)
            $display("int_to_decimal_ascii_fixed_point_unit: match");
        else
            $display("int_to_decimal_ascii_fixed_point_unit: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/itoa_pkg.sv
rtl/itoa_datapath.sv
rtl/itoa_ctrl.sv
rtl/int_to_decimal_ascii_fixed_point_unit.sv
test/int_to_decimal_ascii_fixed_point_unit_tb.sv
